FILE: design/pqtds_pkg.sv
`default_nettype none

package pqtds_pkg;

	localparam int DIST_BITS = 32;
	localparam int CMD_W     = 2;
	localparam int TIDX_W    = 14;
	localparam int CODE_W    = 8;
	localparam int NSUB_W    = 7;

	localparam logic [NSUB_W-1:0] NSUB_RESET = NSUB_W'(8);

	typedef logic [CMD_W-1:0] cmd_t;

	localparam cmd_t CMD_WRITE  = 2'd0;
	localparam cmd_t CMD_CODE   = 2'd1;
	localparam cmd_t CMD_ABSENT = 2'd2;

	typedef struct packed {
		cmd_t                 cmd;
		logic [TIDX_W-1:0]    table_index;
		logic [DIST_BITS-1:0] table_value;
		logic                 table_last;
		logic [CODE_W-1:0]    code_byte;
		logic                 batch_last;
	} pq_item_t;

	typedef struct packed {
		logic [DIST_BITS-1:0] distance;
		logic                 result_last;
	} pq_result_t;

	// Work carried by the single datapath stage after the memory read.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_ADD,
		OP_ADD_EMIT,
		OP_CLEAR,
		OP_EMIT_ZERO
	} op_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
		logic s1_go;
		op_t  op_s1;
		logic ready_s1;
		logic last_s1;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
	} dp_stat_t;

endpackage

`default_nettype wire

FILE: design/pq_table_distance_sum_unit.sv
// Channel   Direction  Handshake                    Payload
// item      in         item_valid / item_ready      pq_item_t
// result    out        result_valid / result_ready  pq_result_t
// cfg       in         cfg_we (no wait)             cfg_wdata, subspace count
//
// One item is taken per cycle unless a waiting result holds the add stage; a result
// is registered when the add stage holding the code byte that completes it moves on.
// The table read and running-sum add each own one register stage.
// Reset clears the ready flag, byte position and sum; the table stays unwritten.
// A waiting result stalls the input only while the item in the add stage also emits.
`default_nettype none

module pq_table_distance_sum_unit
	import pqtds_pkg::*;
#(
	parameter int MAX_SUBSPACES = 64,
	parameter int SUB_CODEWORDS = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire pq_item_t          item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output pq_result_t             result,
	input  wire logic              cfg_we,
	input  wire logic [NSUB_W-1:0] cfg_wdata
);

	localparam int PW = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;

	logic [PW-1:0] pos;
	dp_cmd_t       cmd;
	dp_stat_t      stat;

	pqtds_ctrl #(
		.MAX_SUBSPACES(MAX_SUBSPACES),
		.PW(PW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.pos(pos),
		.cmd(cmd),
		.stat(stat)
	);

	pqtds_datapath #(
		.MAX_SUBSPACES(MAX_SUBSPACES),
		.SUB_CODEWORDS(SUB_CODEWORDS),
		.PW(PW)
	) u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.pos(pos),
		.cmd(cmd),
		.stat(stat),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result)
	);

endmodule

`default_nettype wire

FILE: design/pqtds_datapath.sv
`default_nettype none

module pqtds_datapath
	import pqtds_pkg::*;
#(
	parameter int MAX_SUBSPACES = 64,
	parameter int SUB_CODEWORDS = 256,
	parameter int PW = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire pq_item_t   item,
	input  wire logic [PW-1:0] pos,
	input  wire dp_cmd_t    cmd,
	output dp_stat_t        stat,
	output logic            result_valid,
	input  wire logic       result_ready,
	output pq_result_t      result
);

	localparam int DEPTH = MAX_SUBSPACES * SUB_CODEWORDS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(SUB_CODEWORDS);

	// Code byte reduced modulo the codeword count, as a constant lookup.
	function automatic logic [256*CW-1:0] build_rem();
		logic [256*CW-1:0] t;
		int r;
		t = '0;
		r = 0;
		for (int i = 0; i < 256; i++) begin
			t[i*CW +: CW] = CW'(r);
			r = (r == SUB_CODEWORDS - 1) ? 0 : r + 1;
		end
		return t;
	endfunction

	localparam logic [256*CW-1:0] REM_LUT = build_rem();

	logic [DIST_BITS-1:0] mem [DEPTH];
	logic [DIST_BITS-1:0] rdata_s1;
	logic [DIST_BITS-1:0] sum_q;
	logic                 out_valid_q;
	pq_result_t           result_q;

	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic                 wr_in_range;
	logic [DIST_BITS:0]   sum_wide;
	logic [DIST_BITS-1:0] sum_sat;
	logic [DIST_BITS-1:0] sum_added;
	logic                 emit;

	assign waddr       = AW'(item.table_index);
	assign wr_in_range = 32'(item.table_index) < 32'(DEPTH);
	assign raddr       = AW'(32'(pos) * SUB_CODEWORDS)
		+ AW'(REM_LUT[item.code_byte*CW +: CW]);

	always_ff @(posedge clk) begin
		if (cmd.wr_en && wr_in_range) begin
			mem[waddr] <= item.table_value;
		end
		if (cmd.rd_en) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign sum_wide  = {1'b0, sum_q} + {1'b0, rdata_s1};
	assign sum_sat   = sum_wide[DIST_BITS] ? '1 : sum_wide[DIST_BITS-1:0];
	assign sum_added = cmd.ready_s1 ? sum_sat : sum_q;
	assign emit      = cmd.s1_go && (cmd.op_s1 == OP_ADD_EMIT || cmd.op_s1 == OP_EMIT_ZERO);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= emit || (out_valid_q && !result_ready);
			if (cmd.s1_go) begin
				case (cmd.op_s1)
					OP_ADD:       sum_q <= sum_added;
					OP_ADD_EMIT:  sum_q <= '0;
					OP_CLEAR:     sum_q <= '0;
					OP_EMIT_ZERO: sum_q <= '0;
					default:      sum_q <= sum_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			result_q.result_last <= cmd.last_s1;
			if (cmd.op_s1 == OP_ADD_EMIT && cmd.ready_s1) begin
				result_q.distance <= sum_sat;
			end else begin
				result_q.distance <= '0;
			end
		end
	end

	assign stat.out_free = !out_valid_q || result_ready;
	assign result_valid  = out_valid_q;
	assign result        = result_q;

endmodule

`default_nettype wire

FILE: design/pqtds_ctrl.sv
`default_nettype none

module pqtds_ctrl
	import pqtds_pkg::*;
#(
	parameter int MAX_SUBSPACES = 64,
	parameter int PW = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire pq_item_t          item,
	input  wire logic              cfg_we,
	input  wire logic [NSUB_W-1:0] cfg_wdata,
	output logic [PW-1:0]          pos,
	output dp_cmd_t                cmd,
	input  wire dp_stat_t          stat
);

	typedef enum logic {
		S_IDLE,
		S_ACTIVE
	} state_t;

	localparam logic [9:0] MAXV = 10'(MAX_SUBSPACES);

	state_t              state_q;
	op_t                 op_s1;
	logic                ready_s1;
	logic                last_s1;
	logic [PW-1:0]       pos_q;
	logic                table_ready_q;
	logic [NSUB_W-1:0]   nsub_q;

	logic       accept;
	logic       s1_go;
	logic       s1_emits;
	logic [9:0] m_eff;
	logic [9:0] pos_inc;
	logic       vec_done;
	op_t        op_next;

	always_comb begin
		if (nsub_q == '0) begin
			m_eff = 10'd1;
		end else if (10'(nsub_q) > MAXV) begin
			m_eff = MAXV;
		end else begin
			m_eff = 10'(nsub_q);
		end
	end

	assign pos_inc  = 10'(pos_q) + 10'd1;
	assign vec_done = pos_inc >= m_eff;

	// A stage that will emit may only move on once the output register is free.
	assign s1_emits   = op_s1 == OP_ADD_EMIT || op_s1 == OP_EMIT_ZERO;
	assign s1_go      = (state_q == S_ACTIVE) && (!s1_emits || stat.out_free);
	assign item_ready = (state_q == S_IDLE) || s1_go;
	assign accept     = item_valid && item_ready;

	always_comb begin
		case (item.cmd)
			CMD_WRITE:  op_next = item.table_last ? OP_CLEAR : OP_NOP;
			CMD_CODE:   op_next = vec_done ? OP_ADD_EMIT : OP_ADD;
			CMD_ABSENT: op_next = OP_EMIT_ZERO;
			default:    op_next = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_s1         <= OP_NOP;
			ready_s1      <= 1'b0;
			last_s1       <= 1'b0;
			pos_q         <= '0;
			table_ready_q <= 1'b0;
			nsub_q        <= NSUB_RESET;
		end else begin
			if (cfg_we) begin
				nsub_q <= cfg_wdata;
			end
			if (accept) begin
				state_q  <= S_ACTIVE;
				op_s1    <= op_next;
				ready_s1 <= table_ready_q;
				last_s1  <= item.batch_last;
				case (item.cmd)
					CMD_WRITE: begin
						if (item.table_last) begin
							table_ready_q <= 1'b1;
							pos_q         <= '0;
						end
					end
					CMD_CODE: begin
						pos_q <= vec_done ? '0 : pos_inc[PW-1:0];
					end
					CMD_ABSENT: begin
						pos_q <= '0;
					end
					default: begin
						pos_q <= pos_q;
					end
				endcase
			end else if (s1_go) begin
				state_q <= S_IDLE;
				op_s1   <= OP_NOP;
			end
		end
	end

	assign pos          = pos_q;
	assign cmd.wr_en    = accept && (item.cmd == CMD_WRITE);
	assign cmd.rd_en    = accept && (item.cmd == CMD_CODE);
	assign cmd.s1_go    = s1_go;
	assign cmd.op_s1    = op_s1;
	assign cmd.ready_s1 = ready_s1;
	assign cmd.last_s1  = last_s1;

endmodule

`default_nettype wire
